/* sv/vsc_pkg.sv */
// Package for the version string comparator: beat and tracker state types,
// character codes, register indexes and the delimiter rank function.
// No dependencies; every other file refers to it by scoped names.
package vsc_pkg;

  // Longest string that is counted; later bytes are dropped.
  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned POS_W   = $clog2(MAX_LEN);
  localparam int unsigned DIFF_W  = 9;
  localparam int unsigned RAW_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // Character codes.
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Delimiter ranks; zero means the byte is not a delimiter.
  localparam logic [2:0] RANK_NONE   = 3'd0;
  localparam logic [2:0] RANK_TILDE  = 3'd1;
  localparam logic [2:0] RANK_HYPHEN = 3'd2;
  localparam logic [2:0] RANK_CARET  = 3'd3;
  localparam logic [2:0] RANK_DOT    = 3'd4;
  localparam logic [2:0] RANK_COLON  = 3'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPOCH      = 2'd0,
    CFG_DELIM_RANK = 2'd1,
    CFG_REM_SCAN   = 2'd2,
    CFG_REM_DIGIT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic epoch_enable;
    logic delim_rank_enable;
    logic remainder_scan_enable;
    logic remainder_digit_rule;
  } cfg_t;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] left_char;
    logic       left_present;
    logic [7:0] right_char;
    logic       right_present;
    logic       last;
  } beat_t;

  // Running comparison state of one string pair.
  typedef struct packed {
    logic [CNT_W-1:0]         left_count;
    logic [CNT_W-1:0]         right_count;
    logic signed [DIFF_W-1:0] segment_diff;
    logic                     decided;
    logic signed [DIFF_W-1:0] decided_value;
    logic                     left_colon_found;
    logic [POS_W-1:0]         left_colon_pos;
    logic                     right_colon_found;
    logic [POS_W-1:0]         right_colon_pos;
    logic [7:0]               left_prev_byte;
    logic [7:0]               right_prev_byte;
    logic [7:0]               overhang_byte;
    logic                     overhang_seen;
    logic                     length_overflow;
    logic                     pair_mismatch;
  } trk_state_t;

  function automatic logic [2:0] delim_rank(input logic [7:0] b);
    logic [2:0] r;
    unique case (b)
      CH_TILDE:  r = RANK_TILDE;
      CH_HYPHEN: r = RANK_HYPHEN;
      CH_CARET:  r = RANK_CARET;
      CH_DOT:    r = RANK_DOT;
      CH_COLON:  r = RANK_COLON;
      default:   r = RANK_NONE;
    endcase
    return r;
  endfunction

endpackage

/* sv/vsc_track.sv */
// Tracker for the version string comparator: holds the running state and
// works out the state after the beat in the input register.
// Depends on vsc_pkg.
module vsc_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  vsc_pkg::beat_t      beat,
  input  logic                delim_rank_enable,
  output vsc_pkg::trk_state_t state_nxt,
  output vsc_pkg::trk_state_t state_cur
);

  vsc_pkg::trk_state_t state_r;

  logic                             lp;
  logic                             rp;
  logic [2:0]                       ld;
  logic [2:0]                       rd;
  logic signed [vsc_pkg::DIFF_W-1:0] byte_diff;
  logic signed [vsc_pkg::DIFF_W-1:0] rank_diff;

  assign state_cur = state_r;

  // Bytes at or past the length limit are dropped.
  assign lp = beat.left_present &&
              (state_r.left_count < vsc_pkg::CNT_W'(vsc_pkg::MAX_LEN));
  assign rp = beat.right_present &&
              (state_r.right_count < vsc_pkg::CNT_W'(vsc_pkg::MAX_LEN));

  assign ld        = vsc_pkg::delim_rank(beat.left_char);
  assign rd        = vsc_pkg::delim_rank(beat.right_char);
  assign byte_diff = $signed({beat.left_char[7], beat.left_char}) -
                     $signed({beat.right_char[7], beat.right_char});
  assign rank_diff = vsc_pkg::DIFF_W'($signed({1'b0, ld}) - $signed({1'b0, rd}));

  // State after this beat.
  always_comb begin
    state_nxt = state_r;
    if ((beat.left_present && !lp) || (beat.right_present && !rp)) begin
      state_nxt.length_overflow = 1'b1;
    end
    // Aligned pair comparison.
    if (lp && rp && (state_r.left_count == state_r.right_count)) begin
      if (beat.left_char != beat.right_char) begin
        state_nxt.pair_mismatch = 1'b1;
      end
      if (!state_r.decided) begin
        priority if (ld == vsc_pkg::RANK_NONE && rd == vsc_pkg::RANK_NONE) begin
          if (state_r.segment_diff == '0) begin
            state_nxt.segment_diff = byte_diff;
          end
        end else if (ld == vsc_pkg::RANK_NONE) begin
          state_nxt.decided       = 1'b1;
          state_nxt.decided_value = vsc_pkg::DIFF_W'(1);
        end else if (rd == vsc_pkg::RANK_NONE) begin
          state_nxt.decided       = 1'b1;
          state_nxt.decided_value = -vsc_pkg::DIFF_W'(1);
        end else if (state_r.segment_diff != '0) begin
          state_nxt.decided       = 1'b1;
          state_nxt.decided_value = state_r.segment_diff;
        end else if (delim_rank_enable && (ld != rd)) begin
          state_nxt.decided       = 1'b1;
          state_nxt.decided_value = rank_diff;
        end else begin
          // Two delimiters that do not decide leave the state as it is.
        end
      end
    end
    // First lone byte of the longer string.
    if ((lp != rp) && !state_r.overhang_seen) begin
      state_nxt.overhang_seen = 1'b1;
      state_nxt.overhang_byte = lp ? beat.left_char : beat.right_char;
    end
    // Length, first colon and last byte per side.
    if (lp) begin
      if (beat.left_char == vsc_pkg::CH_COLON && !state_r.left_colon_found) begin
        state_nxt.left_colon_found = 1'b1;
        state_nxt.left_colon_pos   = state_r.left_count[vsc_pkg::POS_W-1:0];
      end
      state_nxt.left_prev_byte = beat.left_char;
      state_nxt.left_count     = state_r.left_count + 1'b1;
    end
    if (rp) begin
      if (beat.right_char == vsc_pkg::CH_COLON && !state_r.right_colon_found) begin
        state_nxt.right_colon_found = 1'b1;
        state_nxt.right_colon_pos   = state_r.right_count[vsc_pkg::POS_W-1:0];
      end
      state_nxt.right_prev_byte = beat.right_char;
      state_nxt.right_count     = state_r.right_count + 1'b1;
    end
  end

  // State register; the last beat of a pair clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= beat.last ? '0 : state_nxt;
    end
  end

endmodule

/* sv/vsc_order.sv */
// Order resolution for the version string comparator: turns the final
// tracker state into the raw order and its clamped sign.
// Depends on vsc_pkg.
module vsc_order (
  input  vsc_pkg::trk_state_t              st,
  input  vsc_pkg::cfg_t                    cfg,
  output logic signed [vsc_pkg::RAW_W-1:0] order_raw,
  output logic signed [1:0]                order_sign
);

  logic signed [vsc_pkg::RAW_W-1:0] lendiff;
  logic signed [vsc_pkg::RAW_W-1:0] colon_offset;
  logic signed [vsc_pkg::RAW_W-1:0] seg_ext;
  logic signed [vsc_pkg::RAW_W-1:0] dec_ext;
  logic signed [vsc_pkg::RAW_W-1:0] sgn;
  logic signed [vsc_pkg::RAW_W-1:0] rem;
  logic                             left_shorter;
  logic [7:0]                       shorter_last;
  logic [7:0]                       ob;
  logic                             shorter_digit;

  assign lendiff = $signed({1'b0, st.left_count}) - $signed({1'b0, st.right_count});
  assign seg_ext = vsc_pkg::RAW_W'(st.segment_diff);
  assign dec_ext = vsc_pkg::RAW_W'(st.decided_value);
  assign left_shorter  = st.left_count < st.right_count;
  assign shorter_last  = left_shorter ? st.left_prev_byte : st.right_prev_byte;
  assign sgn           = left_shorter ? vsc_pkg::RAW_W'(1) : -vsc_pkg::RAW_W'(1);
  assign ob            = st.overhang_seen ? st.overhang_byte : 8'h00;
  assign shorter_digit = (shorter_last >= vsc_pkg::CH_ZERO) &&
                         (shorter_last <= vsc_pkg::CH_NINE);

  // Epoch difference from the first colon on each side.
  always_comb begin
    priority if (st.left_colon_found && st.right_colon_found) begin
      colon_offset = vsc_pkg::RAW_W'($signed({1'b0, st.left_colon_pos}) -
                                     $signed({1'b0, st.right_colon_pos}));
    end else if (st.left_colon_found) begin
      colon_offset = vsc_pkg::RAW_W'(1);
    end else if (st.right_colon_found) begin
      colon_offset = -vsc_pkg::RAW_W'(1);
    end else begin
      colon_offset = '0;
    end
  end

  // Order of the longer string's remainder.
  always_comb begin
    rem = lendiff;
    if (cfg.remainder_scan_enable) begin
      priority if (ob == vsc_pkg::CH_TILDE) begin
        rem = sgn;
      end else if (ob == vsc_pkg::CH_HYPHEN) begin
        rem = '0;
      end else if (ob == vsc_pkg::CH_CARET) begin
        rem = -sgn;
      end else if (st.segment_diff != '0 &&
                   (!cfg.remainder_digit_rule || !shorter_digit)) begin
        rem = seg_ext;
      end else begin
        // Otherwise the length difference decides.
      end
    end else if (st.segment_diff != '0 &&
                 vsc_pkg::delim_rank(ob) != vsc_pkg::RANK_NONE) begin
      rem = seg_ext;
    end
  end

  // Final order in order of precedence.
  always_comb begin
    priority if (st.left_count == '0 && st.right_count == '0) begin
      order_raw = '0;
    end else if (st.left_count == '0) begin
      order_raw = -vsc_pkg::RAW_W'(1);
    end else if (st.right_count == '0) begin
      order_raw = vsc_pkg::RAW_W'(1);
    end else if (!st.pair_mismatch && !st.overhang_seen &&
                 st.left_count == st.right_count) begin
      order_raw = '0;
    end else if (cfg.epoch_enable && colon_offset != '0) begin
      order_raw = colon_offset;
    end else if (st.decided) begin
      order_raw = dec_ext;
    end else if (st.left_count == st.right_count) begin
      order_raw = seg_ext;
    end else begin
      order_raw = rem;
    end
  end

  assign order_sign = order_raw[vsc_pkg::RAW_W-1] ? 2'sb11 :
                      ((order_raw != '0) ? 2'sb01 : 2'sb00);

endmodule

/* sv/version_string_compare.sv */
// Version string comparator, top level: input register, tracker, order
// resolution and result register. Depends on vsc_pkg, vsc_track, vsc_order.
// Throughput: one character pair per cycle, limited only by result backpressure.
// The last pair waits in the input register; its result then moves into the
// result register, which presents it. A full result slot can hold the move.
// Reset (synchronous, active low) clears the configuration, the tracker state
// and both valid flags; no clearing pass is needed.
module version_string_compare (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic                                 cfg_wdata,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_left_char,
  input  logic                                 in_left_present,
  input  logic [7:0]                           in_right_char,
  input  logic                                 in_right_present,
  input  logic                                 in_last,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vsc_pkg::RAW_W-1:0]     out_order_raw,
  output logic signed [1:0]                    out_order_sign,
  output logic                                 out_too_long
);

  vsc_pkg::cfg_t       cfg_r;
  vsc_pkg::beat_t      beat_r;
  logic                beat_valid_r;
  logic                step;
  vsc_pkg::trk_state_t state_nxt;
  vsc_pkg::trk_state_t state_cur;
  logic signed [vsc_pkg::RAW_W-1:0] order_raw;
  logic signed [1:0]   order_sign;
  logic                out_valid_r;
  logic signed [vsc_pkg::RAW_W-1:0] out_raw_r;
  logic signed [1:0]   out_sign_r;
  logic                out_too_long_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (vsc_pkg::cfg_idx_t'(cfg_index))
        vsc_pkg::CFG_EPOCH:      cfg_r.epoch_enable          <= cfg_wdata;
        vsc_pkg::CFG_DELIM_RANK: cfg_r.delim_rank_enable     <= cfg_wdata;
        vsc_pkg::CFG_REM_SCAN:   cfg_r.remainder_scan_enable <= cfg_wdata;
        vsc_pkg::CFG_REM_DIGIT:  cfg_r.remainder_digit_rule  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held beat moves on unless it is a last beat facing a full result slot that is not being taken.
  assign step     = beat_valid_r && (!beat_r.last || !out_valid_r || out_ready);
  assign in_ready = !beat_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (in_ready) begin
      beat_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r.left_char     <= in_left_char;
      beat_r.left_present  <= in_left_present;
      beat_r.right_char    <= in_right_char;
      beat_r.right_present <= in_right_present;
      beat_r.last          <= in_last;
    end
  end

  vsc_track u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .beat              (beat_r),
    .delim_rank_enable (cfg_r.delim_rank_enable),
    .state_nxt         (state_nxt),
    .state_cur         (state_cur)
  );

  vsc_order u_order (
    .st         (state_nxt),
    .cfg        (cfg_r),
    .order_raw  (order_raw),
    .order_sign (order_sign)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && beat_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && beat_r.last) begin
      out_raw_r      <= order_raw;
      out_sign_r     <= order_sign;
      out_too_long_r <= state_nxt.length_overflow;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_order_raw  = out_raw_r;
  assign out_order_sign = out_sign_r;
  assign out_too_long   = out_too_long_r;

  // A new result only follows a last beat leaving the input register.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step && beat_r.last))
    else $error("result beat without a last beat");

  // The tracker is cleared after a last beat.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && beat_r.last) |=> (state_cur.left_count == '0 &&
                               state_cur.right_count == '0 &&
                               !state_cur.decided))
    else $error("tracker state not cleared after last beat");

  // Lengths never pass the saturation limit.
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_cur.left_count <= vsc_pkg::CNT_W'(vsc_pkg::MAX_LEN)) &&
    (state_cur.right_count <= vsc_pkg::CNT_W'(vsc_pkg::MAX_LEN)))
    else $error("string length beyond limit");

  // A held beat that cannot move blocks the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid_r && !step) |-> !in_ready)
    else $error("input accepted while held beat stalls");

endmodule

/* verif/tb.sv */
// Self-checking bench for version_string_compare: directed pairs, then random
// version strings under changing register settings, checked by a local predictor.
// Depends on vsc_pkg and the version_string_compare RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 1000;
  localparam int RANDOM_BEATS = 600;

  typedef logic [7:0] text_t[$];

  // Expected fields of one result beat.
  typedef struct packed {
    logic signed [vsc_pkg::RAW_W-1:0] raw;
    logic signed [1:0]                sign;
    logic                             too_long;
  } order_t;

  // One directed input beat, with a hand-written result where it is obvious.
  typedef struct packed {
    logic [7:0] lc;
    logic       lp;
    logic [7:0] rc;
    logic       rp;
    logic       fin;
    logic       typed;
    order_t     want;
  } script_row_t;

  // Running state of the string pair being compared.
  typedef struct packed {
    int         lcnt;
    int         rcnt;
    int         seg;
    logic       dec;
    int         dval;
    logic       lcol;
    int         lcolpos;
    logic       rcol;
    int         rcolpos;
    logic [7:0] lprev;
    logic [7:0] rprev;
    logic [7:0] ovh;
    logic       ovh_seen;
    logic       ovf;
    logic       mism;
  } pair_track_t;

  localparam script_row_t SCRIPT [23] = '{
    // Both strings empty, then one side empty.
    '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, '{14'sd0, 2'sd0, 1'b0}},
    '{8'hFF, 1'b0, "a", 1'b1, 1'b1, 1'b1, '{-14'sd1, -2'sd1, 1'b0}},
    '{"a", 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, '{14'sd1, 2'sd1, 1'b0}},
    // Identical strings with an epoch.
    '{"1", 1'b1, "1", 1'b1, 1'b0, 1'b0, '0},
    '{vsc_pkg::CH_COLON, 1'b1, vsc_pkg::CH_COLON, 1'b1, 1'b0, 1'b0, '0},
    '{"2", 1'b1, "2", 1'b1, 1'b1, 1'b1, '{14'sd0, 2'sd0, 1'b0}},
    // Extreme byte values are signed.
    '{8'hFF, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1, '{-14'sd1, -2'sd1, 1'b0}},
    '{8'h80, 1'b1, 8'h7F, 1'b1, 1'b1, 1'b1, '{-14'sd255, -2'sd1, 1'b0}},
    '{8'h7F, 1'b1, 8'h80, 1'b1, 1'b1, 1'b1, '{14'sd255, 2'sd1, 1'b0}},
    // Delimiter facing a plain byte.
    '{"1", 1'b1, "1", 1'b1, 1'b0, 1'b0, '0},
    '{vsc_pkg::CH_DOT, 1'b1, "a", 1'b1, 1'b0, 1'b0, '0},
    '{"a", 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, '0},
    // Tilde overhang.
    '{"1", 1'b1, "1", 1'b1, 1'b0, 1'b0, '0},
    '{vsc_pkg::CH_TILDE, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, '0},
    // Two different delimiters.
    '{"1", 1'b1, "1", 1'b1, 1'b0, 1'b0, '0},
    '{vsc_pkg::CH_DOT, 1'b1, vsc_pkg::CH_HYPHEN, 1'b1, 1'b0, 1'b0, '0},
    '{"2", 1'b1, "2", 1'b1, 1'b1, 1'b0, '0},
    // Left stream has a hole in the middle.
    '{"a", 1'b1, "a", 1'b1, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, "b", 1'b1, 1'b0, 1'b0, '0},
    '{"c", 1'b1, "c", 1'b1, 1'b1, 1'b0, '0},
    // Colons at different positions.
    '{"1", 1'b1, "1", 1'b1, 1'b0, 1'b0, '0},
    '{vsc_pkg::CH_COLON, 1'b1, "0", 1'b1, 1'b0, 1'b0, '0},
    '{"0", 1'b1, vsc_pkg::CH_COLON, 1'b1, 1'b1, 1'b0, '0}
  };

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [vsc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic                             cfg_wdata = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       in_left_char = '0;
  logic                             in_left_present = 1'b0;
  logic [7:0]                       in_right_char = '0;
  logic                             in_right_present = 1'b0;
  logic                             in_last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [vsc_pkg::RAW_W-1:0] out_order_raw;
  logic signed [1:0]                out_order_sign;
  logic                             out_too_long;

  order_t        order_q[$];
  pair_track_t   trk = '0;
  vsc_pkg::cfg_t cfg_now = '0;
  text_t         lstr, rstr;
  int            errors = 0;
  int            beats_sent = 0;
  int            stuck = 0;
  int            rx_hold = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;

  version_string_compare DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_char     (in_left_char),
    .in_left_present  (in_left_present),
    .in_right_char    (in_right_char),
    .in_right_present (in_right_present),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_order_raw    (out_order_raw),
    .out_order_sign   (out_order_sign),
    .out_too_long     (out_too_long)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap(input bit calm);
    int p;
    p = $urandom_range(99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int sval(input logic [7:0] b);
    return int'($signed(b));
  endfunction

  function automatic int rank_of(input logic [7:0] b);
    case (b)
      vsc_pkg::CH_TILDE:  return int'(vsc_pkg::RANK_TILDE);
      vsc_pkg::CH_HYPHEN: return int'(vsc_pkg::RANK_HYPHEN);
      vsc_pkg::CH_CARET:  return int'(vsc_pkg::RANK_CARET);
      vsc_pkg::CH_DOT:    return int'(vsc_pkg::RANK_DOT);
      vsc_pkg::CH_COLON:  return int'(vsc_pkg::RANK_COLON);
      default:            return int'(vsc_pkg::RANK_NONE);
    endcase
  endfunction

  // Order of a finished pair: emptiness, identity, epoch, early decision,
  // last segment, then the rule for the longer string's remainder.
  function automatic int settle_order();
    int e, sgn;
    logic [7:0] tail, ob;
    if (trk.lcnt == 0 && trk.rcnt == 0) return 0;
    if (trk.lcnt == 0) return -1;
    if (trk.rcnt == 0) return 1;
    if (!trk.mism && !trk.ovh_seen && trk.lcnt == trk.rcnt) return 0;
    if (cfg_now.epoch_enable) begin
      e = 0;
      if (trk.lcol && trk.rcol) e = trk.lcolpos - trk.rcolpos;
      else if (trk.lcol) e = 1;
      else if (trk.rcol) e = -1;
      if (e != 0) return e;
    end
    if (trk.dec) return trk.dval;
    if (trk.lcnt == trk.rcnt) return trk.seg;
    tail = (trk.lcnt < trk.rcnt) ? trk.lprev : trk.rprev;
    sgn = (trk.lcnt < trk.rcnt) ? 1 : -1;
    ob = trk.ovh_seen ? trk.ovh : 8'h00;
    if (cfg_now.remainder_scan_enable) begin
      if (ob == vsc_pkg::CH_TILDE) return sgn;
      if (ob == vsc_pkg::CH_HYPHEN) return 0;
      if (ob == vsc_pkg::CH_CARET) return -sgn;
      if (trk.seg != 0 &&
          (!cfg_now.remainder_digit_rule ||
           !(tail >= vsc_pkg::CH_ZERO && tail <= vsc_pkg::CH_NINE)))
        return trk.seg;
    end else if (trk.seg != 0 && rank_of(ob) > 0) begin
      return trk.seg;
    end
    return trk.lcnt - trk.rcnt;
  endfunction

  // Fold one accepted beat into the pair state; on the last beat produce the
  // expected result and clear the state.
  function automatic bit predict_beat(input logic [7:0] lc, input bit lp,
                                      input logic [7:0] rc, input bit rp,
                                      input bit fin, output order_t res);
    int ld, rd, r;
    res = '0;
    if (lp && trk.lcnt >= int'(vsc_pkg::MAX_LEN)) begin
      lp = 1'b0;
      trk.ovf = 1'b1;
    end
    if (rp && trk.rcnt >= int'(vsc_pkg::MAX_LEN)) begin
      rp = 1'b0;
      trk.ovf = 1'b1;
    end
    // Aligned pair comparison.
    if (lp && rp && trk.lcnt == trk.rcnt) begin
      ld = rank_of(lc);
      rd = rank_of(rc);
      if (lc != rc) trk.mism = 1'b1;
      if (!trk.dec) begin
        if (ld == 0 && rd == 0) begin
          if (trk.seg == 0) trk.seg = sval(lc) - sval(rc);
        end else if (ld == 0) begin
          trk.dec = 1'b1;
          trk.dval = 1;
        end else if (rd == 0) begin
          trk.dec = 1'b1;
          trk.dval = -1;
        end else if (trk.seg != 0) begin
          trk.dec = 1'b1;
          trk.dval = trk.seg;
        end else if (cfg_now.delim_rank_enable && ld != rd) begin
          trk.dec = 1'b1;
          trk.dval = ld - rd;
        end
      end
    end
    if (lp != rp && !trk.ovh_seen) begin
      trk.ovh_seen = 1'b1;
      trk.ovh = lp ? lc : rc;
    end
    // Per-side length, first colon and last byte.
    if (lp) begin
      if (lc == vsc_pkg::CH_COLON && !trk.lcol) begin
        trk.lcol = 1'b1;
        trk.lcolpos = trk.lcnt;
      end
      trk.lprev = lc;
      trk.lcnt++;
    end
    if (rp) begin
      if (rc == vsc_pkg::CH_COLON && !trk.rcol) begin
        trk.rcol = 1'b1;
        trk.rcolpos = trk.rcnt;
      end
      trk.rprev = rc;
      trk.rcnt++;
    end
    if (!fin) return 1'b0;
    r = settle_order();
    res.raw = r[vsc_pkg::RAW_W-1:0];
    res.sign = (r < 0) ? -2'sd1 : ((r > 0) ? 2'sd1 : 2'sd0);
    res.too_long = trk.ovf;
    trk = '0;
    return 1'b1;
  endfunction

  // Version-like byte: digits, letters and delimiters, now and then any byte.
  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(19);
    if (k < 9) return vsc_pkg::CH_ZERO + 8'($urandom_range(9));
    if (k < 13) return "a" + 8'($urandom_range(25));
    if (k < 18) begin
      case ($urandom_range(4))
        0:       return vsc_pkg::CH_TILDE;
        1:       return vsc_pkg::CH_HYPHEN;
        2:       return vsc_pkg::CH_CARET;
        3:       return vsc_pkg::CH_DOT;
        default: return vsc_pkg::CH_COLON;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic text_t build_version(input int n);
    text_t q;
    repeat (n) q.push_back(rand_char());
    if (n > 2 && $urandom_range(4) == 0) q[$urandom_range(2, 1)] = vsc_pkg::CH_COLON;
    return q;
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(19);
    if (p < 2) return 0;
    if (p < 19) return $urandom_range(10, 1);
    return $urandom_range(30, 11);
  endfunction

  // Left string plus a right string that mostly shares a prefix with it.
  task automatic draw_pair();
    int mode, k;
    text_t t;
    lstr = build_version(pick_len());
    rstr = lstr;
    mode = $urandom_range(99);
    if (mode < 10) begin
      // identical strings
    end else if (mode < 45) begin
      if (rstr.size() > 0) rstr[$urandom_range(rstr.size() - 1)] = rand_char();
    end else if (mode < 65) begin
      k = $urandom_range(rstr.size());
      while (rstr.size() > k) void'(rstr.pop_back());
    end else if (mode < 85) begin
      if ($urandom_range(1) == 0) rstr.push_back(rand_char());
      else rstr.push_back(($urandom_range(1) == 0) ? vsc_pkg::CH_TILDE : vsc_pkg::CH_CARET);
      repeat ($urandom_range(2)) rstr.push_back(rand_char());
    end else begin
      rstr = build_version(pick_len());
    end
    if ($urandom_range(1) == 0) begin
      t = lstr;
      lstr = rstr;
      rstr = t;
    end
  endtask

  // Hold one beat on the input channel until it is accepted.
  task automatic send_beat(input logic [7:0] lc, input bit lp, input logic [7:0] rc,
                           input bit rp, input bit fin);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_left_char     <= lc;
    in_left_present  <= lp;
    in_right_char    <= rc;
    in_right_present <= rp;
    in_last          <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stream lstr and rstr side by side; noisy streams get holes on either side.
  task automatic stream_pair(input bit noisy);
    int li, ri;
    bit lp, rp, fin;
    logic [7:0] lc, rc;
    order_t res;
    li = 0;
    ri = 0;
    do begin
      lp = li < lstr.size();
      rp = ri < rstr.size();
      if (noisy && (lp || rp) && $urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: lp = 1'b0;
          1: rp = 1'b0;
          default: begin
            lp = 1'b0;
            rp = 1'b0;
          end
        endcase
      end
      lc = lp ? lstr[li] : 8'($urandom);
      rc = rp ? rstr[ri] : 8'($urandom);
      fin = (li + lp >= lstr.size()) && (ri + rp >= rstr.size());
      send_beat(lc, lp, rc, rp, fin);
      if (predict_beat(lc, lp, rc, rp, fin, res)) order_q.push_back(res);
      if (lp || rp) beats_sent++;
      li += lp;
      ri += rp;
    end while (!fin);
  endtask

  // Drop valid, wait for every expected result, then let the pipe drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input vsc_pkg::cfg_idx_t idx, input logic v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Write all four registers back to back; only called while idle.
  task automatic load_config(input vsc_pkg::cfg_t c);
    put_reg(vsc_pkg::CFG_EPOCH, c.epoch_enable);
    put_reg(vsc_pkg::CFG_DELIM_RANK, c.delim_rank_enable);
    put_reg(vsc_pkg::CFG_REM_SCAN, c.remainder_scan_enable);
    put_reg(vsc_pkg::CFG_REM_DIGIT, c.remainder_digit_rule);
    cfg_wr_en <= 1'b0;
    cfg_now = c;
  endtask

  // Result side: ready most of the time, with random stalls.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin : rx_pick
      int n;
      n = (rx_calm || $urandom_range(9) < 6) ? 0 : pick_gap(1'b0);
      out_ready <= (n == 0);
      rx_hold <= (n > 0) ? n - 1 : 0;
    end
  end

  // Compare each result beat with the oldest expected order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin : check_result
      order_t want;
      if (order_q.size() == 0) begin
        flag_mismatch("result beat with no expected order");
      end else begin
        want = order_q.pop_front();
        if (out_order_raw !== want.raw)
          flag_mismatch($sformatf("order_raw %0d, expected %0d", out_order_raw, want.raw));
        if (out_order_sign !== want.sign)
          flag_mismatch($sformatf("order_sign %0d, expected %0d", out_order_sign, want.sign));
        if (out_too_long !== want.too_long)
          flag_mismatch($sformatf("too_long %0b, expected %0b", out_too_long, want.too_long));
      end
    end
  end

  // Stop a hung run: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : stimulus
    int phase;
    vsc_pkg::cfg_t cfg;
    order_t res;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats run with the registers at their reset values.
    foreach (SCRIPT[i]) begin
      send_beat(SCRIPT[i].lc, SCRIPT[i].lp, SCRIPT[i].rc, SCRIPT[i].rp, SCRIPT[i].fin);
      if (predict_beat(SCRIPT[i].lc, SCRIPT[i].lp, SCRIPT[i].rc, SCRIPT[i].rp,
                       SCRIPT[i].fin, res))
        order_q.push_back(SCRIPT[i].typed ? SCRIPT[i].want : res);
    end
    wait_idle();

    // Random pairs, a new register setting per phase, all ones and all zeros first.
    phase = 0;
    while (beats_sent < RANDOM_BEATS) begin
      case (phase)
        0:       cfg = '1;
        1:       cfg = '0;
        default: cfg = vsc_pkg::cfg_t'(4'($urandom_range(15)));
      endcase
      load_config(cfg);
      tx_calm = ($urandom_range(3) == 0);
      rx_calm = ($urandom_range(3) == 0);
      repeat ($urandom_range(10, 6)) begin
        draw_pair();
        stream_pair($urandom_range(4) == 0);
      end
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
